// ----- rtl/pbm_pkg.sv -----
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types, register indexes and mode codes of the pixel blender.
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int CH_W = 8;
    localparam int QB   = 8;   // quotient bits of the dodge/burn divide

    typedef enum logic [2:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SCREEN   = 3'd1,
        MODE_DARKEN   = 3'd2,
        MODE_LIGHTEN  = 3'd3,
        MODE_OVERLAY  = 3'd4,
        MODE_DODGE    = 3'd5,
        MODE_BURN     = 3'd6,
        MODE_UNUSED   = 3'd7
    } mode_t;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_AMOUNT = 3'd1;
    localparam logic [2:0] REG_ORDER  = 3'd2;
    localparam logic [2:0] REG_WRED   = 3'd3;
    localparam logic [2:0] REG_WGREEN = 3'd4;
    localparam logic [2:0] REG_WBLUE  = 3'd5;

    typedef logic [CH_W-1:0] pix_t [3];

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] amount;
        logic       order;
        logic [7:0] wr;
        logic [7:0] wg;
        logic [7:0] wb;
    } cfg_t;

    // one step of restoring division: remainder and divisor 9 bits
    typedef struct packed {
        logic [8:0] rem;
        logic       bit_q;
    } div_step_t;

    function automatic div_step_t div_step(input logic [8:0] rem, input logic nb,
                                           input logic [8:0] d);
        div_step_t r;
        logic [9:0] t;
        t = {rem, nb};
        if (t >= {1'b0, d})
        begin
            r.rem = 9'(t - {1'b0, d});
            r.bit_q = 1'b1;
        end
        else
        begin
            r.rem = t[8:0];
            r.bit_q = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/pbm_luma.sv -----
// ----------------------------------------------------------------------------
// pbm_luma
// Registered weighted luma of one pixel, saturated to 8 bits. Two stages.
// ----------------------------------------------------------------------------
module pbm_luma
    import pbm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic       order,
    input  logic [7:0] wr,
    input  logic [7:0] wg,
    input  logic [7:0] wb,
    input  logic [7:0] c0,
    input  logic [7:0] c1,
    input  logic [7:0] c2,
    output logic [7:0] luma
);

    logic [15:0] pr_reg, pg_reg, pb_reg;
    logic [7:0]  luma_reg;
    logic [17:0] sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg <= wr * (order ? c2 : c0);
            pg_reg <= wg * c1;
            pb_reg <= wb * (order ? c0 : c2);
            luma_reg <= (sum[17:16] != 2'd0) ? 8'hff : sum[15:8];
        end
    end

    assign sum  = 18'(pr_reg) + 18'(pg_reg) + 18'(pb_reg);
    assign luma = luma_reg;

endmodule

// ----- rtl/pbm_divider.sv -----
// ----------------------------------------------------------------------------
// pbm_divider
// Pipelined restoring divide of (n << 8) / d; sat flags a quotient above 255.
// Two quotient bits per stage, four stages after an overflow check.
// ----------------------------------------------------------------------------
module pbm_divider
    import pbm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] num,
    input  logic [7:0] den,
    output logic       sat,    // quotient above 255
    output logic [7:0] quo
);

    localparam int NS = QB / 2;

    logic [8:0] rem_reg [NS+1];
    logic [8:0] d_reg   [NS+1];
    logic [7:0] q_reg   [NS+1];
    logic       sat_reg [NS+1];

    // (n<<8)/d > 255 exactly when n >= d; then quotient bits are not needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num};
            d_reg[0]   <= {1'b0, den};
            q_reg[0]   <= 8'd0;
            sat_reg[0] <= (num >= den);
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        div_step_t s1, s2;
        always_comb
        begin
            s1 = div_step(rem_reg[s], 1'b0, d_reg[s]);
            s2 = div_step(s1.rem, 1'b0, d_reg[s]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= s2.rem;
                d_reg[s+1]   <= d_reg[s];
                q_reg[s+1]   <= {q_reg[s][5:0], s1.bit_q, s2.bit_q};
                sat_reg[s+1] <= sat_reg[s];
            end
        end
    end

    assign sat = sat_reg[NS];
    assign quo = q_reg[NS];

endmodule

// ----- rtl/pbm_core.sv -----
// ----------------------------------------------------------------------------
// pbm_core
// Blend datapath: effect per channel, luma pick, crossfade. Fixed latency.
// ----------------------------------------------------------------------------
module pbm_core
    import pbm_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  cfg_t       cfg,
    input  logic [7:0] a_in [3],
    input  logic [7:0] b_in [3],
    output logic [7:0] y    [3]
);

    // Stages: S0 capture, S1..S5 divider/luma wait, S6 select, S7 mix, S8 shift
    localparam int DL = 6;   // delay of a/b to select stage

    logic [7:0] a_d_reg [DL][3];
    logic [7:0] b_d_reg [DL][3];
    logic [7:0] mul_d_reg [DL-1][3];
    logic [7:0] scr_d_reg [DL-1][3];
    logic [7:0] la, lb;
    logic [7:0] la_d_reg [3], lb_d_reg [3];
    logic       dsat [3], bsat [3];
    logic [7:0] dq [3], bq [3];
    logic       b255_reg [DL-1][3], b0_reg [DL-1][3];
    logic [7:0] p_reg [3];
    logic [7:0] a7_reg [3], b7_reg [3];
    logic [16:0] m1_reg [3], m2_reg [3];
    logic [7:0] y_reg [3];
    logic [7:0] w1, w2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_d_reg[0][c] <= a_in[c];
                b_d_reg[0][c] <= b_in[c];
                for (int k = 0; k < DL-1; k++)
                begin
                    a_d_reg[k+1][c] <= a_d_reg[k][c];
                    b_d_reg[k+1][c] <= b_d_reg[k][c];
                end
                mul_d_reg[0][c] <= 8'((16'(a_d_reg[0][c]) * 16'(b_d_reg[0][c])) >> 8);
                scr_d_reg[0][c] <= 8'd255 - 8'(({8'd0, ~a_d_reg[0][c]} *
                                                 {8'd0, ~b_d_reg[0][c]}) >> 8);
                b255_reg[0][c] <= (b_d_reg[0][c] == 8'hff);
                b0_reg[0][c]   <= (b_d_reg[0][c] == 8'h00);
                for (int k = 1; k < DL-1; k++)
                begin
                    mul_d_reg[k][c] <= mul_d_reg[k-1][c];
                    scr_d_reg[k][c] <= scr_d_reg[k-1][c];
                    b255_reg[k][c]  <= b255_reg[k-1][c];
                    b0_reg[k][c]    <= b0_reg[k-1][c];
                end
            end
            // luma is registered at stage 2 in pbm_luma; hold to align with select stage
            la_d_reg[0] <= la;  lb_d_reg[0] <= lb;
            la_d_reg[1] <= la_d_reg[0]; lb_d_reg[1] <= lb_d_reg[0];
            la_d_reg[2] <= la_d_reg[1]; lb_d_reg[2] <= lb_d_reg[1];
        end
    end

    pbm_luma u_la (.clk, .en, .order(cfg.order), .wr(cfg.wr), .wg(cfg.wg), .wb(cfg.wb),
                   .c0(a_d_reg[0][0]), .c1(a_d_reg[0][1]), .c2(a_d_reg[0][2]), .luma(la));
    pbm_luma u_lb (.clk, .en, .order(cfg.order), .wr(cfg.wr), .wg(cfg.wg), .wb(cfg.wb),
                   .c0(b_d_reg[0][0]), .c1(b_d_reg[0][1]), .c2(b_d_reg[0][2]), .luma(lb));

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        pbm_divider u_dodge (.clk, .en, .num(a_d_reg[0][c]), .den(~b_d_reg[0][c]),
                             .sat(dsat[c]), .quo(dq[c]));
        pbm_divider u_burn  (.clk, .en, .num(~a_d_reg[0][c]), .den(b_d_reg[0][c]),
                             .sat(bsat[c]), .quo(bq[c]));
    end

    // select stage: inputs in a_d_reg[DL-1] (aligned with divider outputs)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                unique case (mode_t'(cfg.mode))
                    MODE_MULTIPLY: p_reg[c] <= mul_d_reg[DL-2][c];
                    MODE_SCREEN:   p_reg[c] <= scr_d_reg[DL-2][c];
                    MODE_DARKEN:   p_reg[c] <= (la_d_reg[2] <= lb_d_reg[2])
                                               ? a_d_reg[DL-1][c] : b_d_reg[DL-1][c];
                    MODE_LIGHTEN:  p_reg[c] <= (la_d_reg[2] >= lb_d_reg[2])
                                               ? a_d_reg[DL-1][c] : b_d_reg[DL-1][c];
                    MODE_OVERLAY:  p_reg[c] <= la_d_reg[2][7] ? scr_d_reg[DL-2][c]
                                                              : mul_d_reg[DL-2][c];
                    MODE_DODGE:    p_reg[c] <= (b255_reg[DL-2][c] || dsat[c]) ? 8'hff
                                                                              : dq[c];
                    MODE_BURN:     p_reg[c] <= (b0_reg[DL-2][c] || bsat[c]) ? 8'h00
                                                                            : 8'hff - bq[c];
                    MODE_UNUSED:   p_reg[c] <= a_d_reg[DL-1][c];
                    default:       p_reg[c] <= a_d_reg[DL-1][c];
                endcase
                a7_reg[c] <= a_d_reg[DL-1][c];
                b7_reg[c] <= b_d_reg[DL-1][c];
            end
        end
    end

    assign w1 = cfg.amount[7] ? {~cfg.amount[6:0], 1'b0} : {cfg.amount[6:0], 1'b0};
    assign w2 = cfg.amount[7] ? {cfg.amount[6:0], 1'b0} : ~{cfg.amount[6:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m1_reg[c] <= 17'(w1 * p_reg[c]);
                m2_reg[c] <= 17'(w2 * (cfg.amount[7] ? b7_reg[c] : a7_reg[c]));
                y_reg[c]  <= 8'((m1_reg[c] + m2_reg[c]) >> 8);
            end
        end
    end

    assign y = y_reg;

endmodule

// ----- rtl/pixel_blend_modes.sv -----
// ----------------------------------------------------------------------------
// pixel_blend_modes
// Seven-mode pixel blender with crossfade, streaming in and out.
// ----------------------------------------------------------------------------
// One pixel pair enters per clock unless the output stalls; its result
// passes nine register stages. The latency is set by the dodge/burn
// divider (two quotient bits per stage) that every item passes through.
// The pipeline advances while its output register is empty or drained,
// so a downstream stall freezes it with nothing lost. The user must write
// configuration only while the pipeline is empty; nothing enforces it.
module pixel_blend_modes
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // first_ch0..2, second_ch0..2
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_ch0..2
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int LAT = 9;

    cfg_t       cfg_reg;
    logic [LAT-1:0] vld_reg;
    logic       en;
    logic [7:0] a [3], b [3], y [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: MODE_MULTIPLY, amount: 8'd128, order: 1'b0,
                         wr: 8'd77, wg: 8'd150, wb: 8'd29};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[2:0];
                REG_AMOUNT: cfg_reg.amount <= cfg_data;
                REG_ORDER:  cfg_reg.order  <= cfg_data[0];
                REG_WRED:   cfg_reg.wr     <= cfg_data;
                REG_WGREEN: cfg_reg.wg     <= cfg_data;
                REG_WBLUE:  cfg_reg.wb     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        assign a[c] = s_axis_tdata[8*c +: 8];
        assign b[c] = s_axis_tdata[24 + 8*c +: 8];
        assign m_axis_tdata[8*c +: 8] = y[c];
    end

    pbm_core u_core (.clk, .en, .cfg(cfg_reg), .a_in(a), .b_in(b), .y(y));

    assign m_axis_tvalid = vld_reg[LAT-1];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transaction not tracked");

endmodule
